// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros for the sorted key map core.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SKM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SKM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/skm_pkg.sv =====
// Package for the sorted key map core: item types, operation codes,
// sequencer states and default sizes. No dependencies.
package skm_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int DEFAULT_KEY_BITS    = 32;
  localparam int FIELD_KEY_W         = 32;
  localparam int VAL_W               = 32;

  typedef enum logic [1:0] {
    OP_LOOKUP     = 2'd0,
    OP_REGISTER   = 2'd1,
    OP_UNREGISTER = 2'd2
  } op_t;

  typedef struct packed {
    op_t                    operation;
    logic [FIELD_KEY_W-1:0] key;
    logic [VAL_W-1:0]       mapped_type;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] stored_value;
    logic [VAL_W-1:0] resolved_type;
    logic             status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_SHIFT,
    ST_INS,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/sorted_key_map_binary_search_core.sv =====
// Sorted key/value map core: binary-search lookup, ordered insert, unregister.
// Depends on skm_pkg and assert_macros.svh.
//
// Usage:
//   in channel (in_valid/in_stall/in_data) carries one operation per item:
//   lookup, register or unregister. out channel (out_valid/out_stall/out_data)
//   returns exactly one result item per input item, in order.
//   in_stall is high while an item is being worked on; one item at a time.
//   The search makes at most clog2(TABLE_DEPTH)+1 probes. A register that
//   inserts a new key at position pos first moves entries pos up to the
//   count one place up, then writes the new key and value at pos.
//   The search shares one key/value memory read port; each probe is a
//   registered read, then a compare. The insert shift moves one entry a cycle.
//   The result sits in an output register; if out_stall holds it, a finished
//   item waits before loading it. The next item may be accepted in the cycle
//   that out_valid first goes high, even while that result waits.
//   Reset (rst_n low, synchronous) empties the table and drops any result.
//   Memory contents are not cleared; only entries below the count are read.

module sorted_key_map_binary_search_core #(
  parameter int TABLE_DEPTH = skm_pkg::DEFAULT_TABLE_DEPTH,
  parameter int KEY_BITS    = skm_pkg::DEFAULT_KEY_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  skm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output skm_pkg::out_item_t out_data
);
  import skm_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // storage
  logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];
  logic [VAL_W-1:0]    val_mem [TABLE_DEPTH];
  logic [KEY_BITS-1:0] rd_key_r;
  logic [VAL_W-1:0]    rd_val_r;

  // control
  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            wr_pend_r, wr_pend_nxt;

  // datapath
  op_t                 op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [VAL_W-1:0]    mapped_r, mapped_nxt;
  logic [CW-1:0]       lo_r, lo_nxt;
  logic [CW-1:0]       hi_r, hi_nxt;
  logic [CW-1:0]       mid_r, mid_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  logic [AW-1:0]       wa_r, wa_nxt;
  logic                res_found_r, res_found_nxt;
  logic [VAL_W-1:0]    res_value_r, res_value_nxt;
  logic                res_status_r, res_status_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // memory port
  logic [AW-1:0]       rd_addr;
  logic                key_we, val_we;
  logic [AW-1:0]       wr_addr;
  logic [KEY_BITS-1:0] wr_key;
  logic [VAL_W-1:0]    wr_val;

  // helpers
  logic [63:0]         key_in_wide;
  logic [KEY_BITS-1:0] key_in_m;
  logic [63:0]         key_r_ext;
  logic [CW-1:0]       mid;
  logic [CW-1:0]       i_dec;

  assign key_in_wide = {32'b0, in_data.key};
  assign key_in_m    = key_in_wide[KEY_BITS-1:0];
  assign key_r_ext   = 64'(key_r);
  assign mid         = lo_r + ((hi_r - lo_r) >> 1);
  assign i_dec       = i_r - 1'b1;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    wr_pend_nxt    = 1'b0;
    op_nxt         = op_r;
    key_nxt        = key_r;
    mapped_nxt     = mapped_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    pos_nxt        = pos_r;
    i_nxt          = i_r;
    wa_nxt         = wa_r;
    res_found_nxt  = res_found_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;
    rd_addr        = mid[AW-1:0];
    key_we         = 1'b0;
    val_we         = 1'b0;
    wr_addr        = pos_r[AW-1:0];
    wr_key         = key_r;
    wr_val         = mapped_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.operation;
          key_nxt    = key_in_m;
          mapped_nxt = in_data.mapped_type;
          lo_nxt     = '0;
          hi_nxt     = cnt_r;
          state_nxt  = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid;
          state_nxt = ST_CMP;
        end else begin
          // key absent; lo is the insertion point
          res_found_nxt  = 1'b0;
          res_value_nxt  = '0;
          res_status_nxt = 1'b0;
          pos_nxt        = lo_r;
          state_nxt      = ST_DONE;
          if (op_r == OP_REGISTER) begin
            if (cnt_r < CW'(TABLE_DEPTH)) begin
              i_nxt         = cnt_r;
              res_value_nxt = mapped_r;
              state_nxt     = ST_SHIFT;
            end else begin
              res_status_nxt = 1'b1;
            end
          end
        end
      end
      ST_CMP: begin
        if (rd_key_r == key_r) begin
          res_found_nxt  = 1'b1;
          res_status_nxt = 1'b0;
          wr_addr        = mid_r[AW-1:0];
          state_nxt      = ST_DONE;
          unique case (op_r)
            OP_REGISTER: begin
              val_we        = 1'b1;
              wr_val        = mapped_r;
              res_value_nxt = mapped_r;
            end
            OP_UNREGISTER: begin
              val_we        = 1'b1;
              wr_val        = '0;
              res_value_nxt = '0;
            end
            default: begin
              res_value_nxt = rd_val_r;
            end
          endcase
        end else if (key_r < rd_key_r) begin
          hi_nxt    = mid_r;
          state_nxt = ST_PROBE;
        end else begin
          lo_nxt    = mid_r + 1'b1;
          state_nxt = ST_PROBE;
        end
      end
      ST_SHIFT: begin
        // read entry i-1 while the entry read last cycle lands one place up
        if (wr_pend_r) begin
          key_we  = 1'b1;
          val_we  = 1'b1;
          wr_addr = wa_r;
          wr_key  = rd_key_r;
          wr_val  = rd_val_r;
        end
        if (i_r > pos_r) begin
          rd_addr     = i_dec[AW-1:0];
          wr_pend_nxt = 1'b1;
          wa_nxt      = i_r[AW-1:0];
          i_nxt       = i_dec;
        end else begin
          state_nxt = ST_INS;
        end
      end
      ST_INS: begin
        key_we    = 1'b1;
        val_we    = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.found         = res_found_r;
          out_data_nxt.stored_value  = res_value_r;
          out_data_nxt.resolved_type = (res_value_r != '0) ? res_value_r
                                                           : key_r_ext[VAL_W-1:0];
          out_data_nxt.status        = res_status_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      wr_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      wr_pend_r   <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    mapped_r     <= mapped_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    pos_r        <= pos_nxt;
    i_r          <= i_nxt;
    wa_r         <= wa_nxt;
    res_found_r  <= res_found_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_val_r <= val_mem[rd_addr];
  end

  `SKM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(TABLE_DEPTH), "entry count above depth")
  `SKM_ASSERT_NXT(a_ins_count, state_r == ST_INS, cnt_r == $past(cnt_r) + 1'b1, "count stuck")
  `SKM_ASSERT_IMP(a_shift_range, state_r == ST_SHIFT, i_r >= pos_r, "shift below insert point")
  `SKM_ASSERT_IMP(a_full_hit, out_valid_r && out_data_r.status, !out_data_r.found, "full on hit")

endmodule
